### rtl/core/traversal_time_history_table_macros.svh
// assertion helpers shared by the checker
`ifndef TRAVERSAL_TIME_HISTORY_TABLE_MACROS_SVH
`define TRAVERSAL_TIME_HISTORY_TABLE_MACROS_SVH

// same-cycle implication
`define TTHT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttht check failed");

// next-cycle implication
`define TTHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttht check failed");

`endif

### rtl/core/ttht_pkg.sv
`default_nettype none

package ttht_pkg;

  localparam int HistEntriesDef  = 256;
  localparam int MapWidthDef     = 12288;
  localparam int MapHeightDef    = 12288;
  localparam int TrackTypesDef   = 8;
  localparam int FractionBitsDef = 16;

  localparam int ZLimit    = 1020;
  localparam int TadLimit  = 44 * 8;
  localparam int MaxConf   = 16;
  localparam int ConfShift = $clog2(MaxConf);

  localparam int ConfW     = 5;
  localparam int MeanW     = 48;
  localparam int DayW      = 32;
  localparam int TimeW     = 64;
  localparam int CountW    = 10;
  localparam int WeightW   = 11;
  localparam int ProdW     = TimeW + CountW;

  localparam logic [15:0] RetentionReset = 16'd30;
  localparam logic [3:0]  PriorReset     = 4'd4;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_AGING  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_INVALID  = 3'd2,
    ST_FULL     = 3'd3,
    ST_QUERY    = 3'd4,
    ST_DONE     = 3'd5
  } status_t;

  typedef enum logic {
    CFG_RETENTION = 1'b0,
    CFG_PRIOR     = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] edge_x;
    logic signed [15:0] edge_y;
    logic signed [15:0] edge_z;
    logic [8:0]         edge_tad;
    logic [7:0]         track_type;
    logic [47:0]        duration;
    logic [31:0]        today;
    logic [63:0]        free_flow_time;
    logic [63:0]        active_elapsed;
    logic [9:0]         active_count;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] travel_time;
    logic [31:0] revision;
    logic [8:0]  entries_used;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [8:0]         tad;
    logic [7:0]         tt;
  } key_t;

  typedef struct packed {
    key_t              key;
    logic [MeanW-1:0]  mean;
    logic [ConfW-1:0]  conf;
    logic [DayW-1:0]   day;
  } entry_t;

  function automatic logic [TimeW-1:0] sat_add64(input logic [TimeW-1:0] a,
                                                 input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? '1 : s[TimeW-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/ttht_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module ttht_div #(
  parameter int DIVIDEND_W = ttht_pkg::TimeW,
  parameter int DIVISOR_W  = ttht_pkg::WeightW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CntW = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  div_r, div_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  always_comb begin
    trial    = {rem_r, quo_r[DIVIDEND_W-1]};
    diff     = trial - {1'b0, div_r};
    ge       = trial >= {1'b0, div_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      div_nxt = divisor;
      cnt_nxt = CntW'(DIVIDEND_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
      rem_nxt = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

### rtl/core/traversal_time_history_table.sv
`default_nettype none

// traversal time history table
// an item is taken on start while busy is low; busy stays high until the
// result strobe, which is high for one cycle with out_payload. every item
// gives exactly one result and the receiver cannot stall it.
// entries live in one single-port-read, single-port-write memory; valid
// bits are flip-flops, so reset and clear drop every entry at once.
// what each item does after start:
//   clear, or record of an invalid edge or duration: straight to the result
//   aging: scans every entry (one read per cycle, written back behind the read)
//   record of a new key, or of a key at full confidence: scan, then result
//   record of a key below full confidence: scan, one product, then the divide
//   query of an unknown edge with no vehicles on it: scan, then result
//   query: scan, three products on the shared multiplier, then a
//   64-bit divide at one quotient bit per cycle; no divide at zero weight
// configuration writes are always taken and act at once.
// after reset the table is empty, revision is zero, retention is 30 days
// and the prior weight is 4.
module traversal_time_history_table #(
  parameter int HISTORY_ENTRIES = ttht_pkg::HistEntriesDef,
  parameter int MAP_WIDTH       = ttht_pkg::MapWidthDef,
  parameter int MAP_HEIGHT      = ttht_pkg::MapHeightDef,
  parameter int TRACK_TYPES     = ttht_pkg::TrackTypesDef,
  parameter int FRACTION_BITS   = ttht_pkg::FractionBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ttht_pkg::in_item_t  in_payload,
  output logic                out_strobe,
  output ttht_pkg::out_item_t out_payload,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ttht_pkg::cfg_idx_t  cfg_index,
  input  logic [15:0]         cfg_data
);

  import ttht_pkg::*;

  localparam int AddrW = (HISTORY_ENTRIES > 1) ? $clog2(HISTORY_ENTRIES) : 1;
  localparam int CntW  = $clog2(HISTORY_ENTRIES + 1);
  localparam logic [AddrW:0] LastAddr = (AddrW + 1)'(HISTORY_ENTRIES);
  localparam logic [MeanW-1:0] MaxDur = MeanW'(64'h7FFF_FFFF << FRACTION_BITS);

  localparam logic [1:0] PH_HIST  = 2'd0;
  localparam logic [1:0] PH_ACT   = 2'd1;
  localparam logic [1:0] PH_PRIOR = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_MUL  = 6'b000100,
    S_ACC  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  in_item_t             item_r, item_nxt;
  logic                 bad_r, bad_nxt;
  logic [AddrW:0]       scan_r, scan_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [AddrW-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 found_r, found_nxt;
  entry_t               hit_r, hit_nxt;
  logic [AddrW-1:0]     hit_idx_r, hit_idx_nxt;
  logic                 free_r, free_nxt;
  logic [AddrW-1:0]     free_idx_r, free_idx_nxt;
  logic                 evict_r, evict_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [TimeW-1:0]     acc_r, acc_nxt;
  logic [WeightW-1:0]   w_r, w_nxt;
  logic [ProdW-1:0]     prod_r, prod_nxt;
  logic [HISTORY_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic [31:0]          rev_r, rev_nxt;
  logic [15:0]          ret_r, ret_nxt;
  logic [3:0]           pw_r, pw_nxt;
  logic                 out_vld_r, out_vld_nxt;
  out_item_t            out_r, out_nxt;

  entry_t               mem [HISTORY_ENTRIES];
  entry_t               rd_data_r;
  logic                 mem_we;
  logic [AddrW-1:0]     mem_wa;
  entry_t               mem_wd;

  key_t                 cur_key;
  logic                 edge_ok;
  logic                 dur_ok;
  logic [TimeW-1:0]     mul_a;
  logic [CountW-1:0]    mul_b;
  logic [TimeW-1:0]     prod_sat;
  logic [TimeW-1:0]     term;
  logic                 div_start;
  logic                 div_done;
  logic [TimeW-1:0]     div_q;
  logic [DayW-1:0]      age;
  logic [MeanW-1:0]     ema;

  ttht_div #(
    .DIVIDEND_W(TimeW),
    .DIVISOR_W (WeightW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(acc_nxt),
    .divisor (w_nxt),
    .done    (div_done),
    .quotient(div_q)
  );

  always_comb begin
    cur_key.x   = item_r.edge_x;
    cur_key.y   = item_r.edge_y;
    cur_key.z   = item_r.edge_z;
    cur_key.tad = item_r.edge_tad;
    cur_key.tt  = item_r.track_type;
  end

  // edge and duration checks on the incoming item
  always_comb begin
    edge_ok = (in_payload.edge_x >= 0) && (in_payload.edge_x < MAP_WIDTH)
           && (in_payload.edge_y >= 0) && (in_payload.edge_y < MAP_HEIGHT)
           && (in_payload.edge_z >= 0) && (in_payload.edge_z <= ZLimit)
           && (in_payload.track_type < TRACK_TYPES)
           && (in_payload.edge_tad < TadLimit);
    dur_ok  = (in_payload.duration != '0) && (in_payload.duration <= MaxDur);
  end

  // multiplier operands by phase
  always_comb begin
    mul_a = TimeW'(hit_r.mean);
    mul_b = found_r ? CountW'(hit_r.conf) : '0;
    if (item_r.op == OP_QUERY) begin
      case (phase_r)
        PH_HIST: begin
          mul_a = TimeW'(hit_r.mean);
          mul_b = found_r ? CountW'(hit_r.conf) : '0;
        end
        PH_ACT: begin
          mul_a = item_r.free_flow_time;
          mul_b = item_r.active_count;
        end
        PH_PRIOR: begin
          mul_a = item_r.free_flow_time;
          mul_b = CountW'(pw_r);
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  always_comb begin
    prod_sat = (prod_r[ProdW-1:TimeW] != '0) ? '1 : prod_r[TimeW-1:0];
    if (mul_b == '0) begin
      term = '0;
    end else if (phase_r == PH_ACT) begin
      term = (item_r.active_elapsed > prod_sat) ? item_r.active_elapsed : prod_sat;
    end else begin
      term = prod_sat;
    end
    age = item_r.today - rd_data_r.day;
    if (item_r.duration >= hit_r.mean) begin
      ema = hit_r.mean + ((item_r.duration - hit_r.mean) >> ConfShift);
    end else begin
      ema = hit_r.mean - ((hit_r.mean - item_r.duration) >> ConfShift);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    bad_nxt      = bad_r;
    scan_nxt     = scan_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    found_nxt    = found_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    evict_nxt    = evict_r;
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    w_nxt        = w_r;
    prod_nxt     = prod_r;
    valid_nxt    = valid_r;
    cnt_nxt      = cnt_r;
    rev_nxt      = rev_r;
    ret_nxt      = ret_r;
    pw_nxt       = pw_r;
    out_vld_nxt  = 1'b0;
    out_nxt      = out_r;
    mem_we       = 1'b0;
    mem_wa       = rd_idx_r;
    mem_wd       = rd_data_r;
    div_start    = 1'b0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_RETENTION: ret_nxt = cfg_data;
        CFG_PRIOR:     pw_nxt  = cfg_data[3:0];
        default:       ret_nxt = ret_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_payload;
          bad_nxt   = !(edge_ok && dur_ok);
          scan_nxt  = '0;
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          evict_nxt = 1'b0;
          phase_nxt = PH_HIST;
          acc_nxt   = '0;
          w_nxt     = '0;
          if (in_payload.op == OP_CLEAR ||
              (in_payload.op == OP_RECORD && !(edge_ok && dur_ok))) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (scan_r != LastAddr) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = scan_r[AddrW-1:0];
          scan_nxt   = scan_r + 1'b1;
        end
        // entry read last cycle
        if (rd_vld_r) begin
          if (item_r.op == OP_AGING) begin
            if (valid_r[rd_idx_r]) begin
              mem_we = 1'b1;
              if (rd_data_r.day != item_r.today && rd_data_r.conf != '0) begin
                mem_wd.conf = rd_data_r.conf - 1'b1;
              end
              if (rd_data_r.day > item_r.today || age > DayW'(ret_r)) begin
                valid_nxt[rd_idx_r] = 1'b0;
                cnt_nxt   = cnt_r - 1'b1;
                evict_nxt = 1'b1;
              end
            end
          end else begin
            if (valid_r[rd_idx_r] && rd_data_r.key == cur_key && !found_r) begin
              found_nxt   = 1'b1;
              hit_nxt     = rd_data_r;
              hit_idx_nxt = rd_idx_r;
            end
            if (!valid_r[rd_idx_r] && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = rd_idx_r;
            end
          end
        end
        if (scan_r == LastAddr && !rd_vld_r) begin
          case (item_r.op)
            OP_RECORD: begin
              state_nxt = (found_r && hit_r.conf < ConfW'(MaxConf)) ? S_MUL : S_DONE;
            end
            OP_QUERY: begin
              state_nxt = (!found_r && item_r.active_count == '0) ? S_DONE : S_MUL;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_MUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_ACC;
      end

      S_ACC: begin
        if (item_r.op == OP_RECORD) begin
          acc_nxt   = sat_add64(prod_sat, TimeW'(item_r.duration));
          w_nxt     = WeightW'(hit_r.conf) + 1'b1;
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          acc_nxt = sat_add64(acc_r, term);
          w_nxt   = w_r + WeightW'(mul_b);
          if (phase_r == PH_PRIOR) begin
            if (w_nxt == '0) begin
              state_nxt = S_DONE;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end else begin
            phase_nxt = phase_r + 1'b1;
            state_nxt = S_MUL;
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        out_nxt.travel_time = '0;
        out_nxt.status      = ST_DONE;
        case (item_r.op)
          OP_CLEAR: begin
            valid_nxt = '0;
            cnt_nxt   = '0;
            rev_nxt   = rev_r + 1'b1;
          end
          OP_AGING: begin
            rev_nxt = rev_r + 32'(evict_r);
          end
          OP_QUERY: begin
            out_nxt.status = ST_QUERY;
            if (w_r == '0 || div_q < item_r.free_flow_time) begin
              out_nxt.travel_time = item_r.free_flow_time;
            end else begin
              out_nxt.travel_time = div_q;
            end
          end
          OP_RECORD: begin
            if (bad_r) begin
              out_nxt.status = ST_INVALID;
            end else if (!found_r) begin
              if (!free_r) begin
                out_nxt.status = ST_FULL;
              end else begin
                mem_we      = 1'b1;
                mem_wa      = free_idx_r;
                mem_wd.key  = cur_key;
                mem_wd.mean = item_r.duration;
                mem_wd.conf = ConfW'(1);
                mem_wd.day  = item_r.today;
                valid_nxt[free_idx_r] = 1'b1;
                cnt_nxt        = cnt_r + 1'b1;
                rev_nxt        = rev_r + 1'b1;
                out_nxt.status = ST_INSERTED;
              end
            end else begin
              mem_we      = 1'b1;
              mem_wa      = hit_idx_r;
              mem_wd      = hit_r;
              mem_wd.day  = item_r.today;
              if (hit_r.conf < ConfW'(MaxConf)) begin
                mem_wd.mean = div_q[MeanW-1:0];
                mem_wd.conf = hit_r.conf + 1'b1;
              end else begin
                mem_wd.mean = ema;
              end
              rev_nxt        = rev_r + 1'b1;
              out_nxt.status = ST_UPDATED;
            end
          end
          default: out_nxt.status = ST_DONE;
        endcase
        out_nxt.revision     = rev_nxt;
        out_nxt.entries_used = 9'(cnt_nxt);
        out_vld_nxt          = 1'b1;
        state_nxt            = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bad_r     <= 1'b0;
      scan_r    <= '0;
      rd_vld_r  <= 1'b0;
      found_r   <= 1'b0;
      free_r    <= 1'b0;
      evict_r   <= 1'b0;
      phase_r   <= PH_HIST;
      valid_r   <= '0;
      cnt_r     <= '0;
      rev_r     <= '0;
      ret_r     <= RetentionReset;
      pw_r      <= PriorReset;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      bad_r     <= bad_nxt;
      scan_r    <= scan_nxt;
      rd_vld_r  <= rd_vld_nxt;
      found_r   <= found_nxt;
      free_r    <= free_nxt;
      evict_r   <= evict_nxt;
      phase_r   <= phase_nxt;
      valid_r   <= valid_nxt;
      cnt_r     <= cnt_nxt;
      rev_r     <= rev_nxt;
      ret_r     <= ret_nxt;
      pw_r      <= pw_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    rd_idx_r   <= rd_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    acc_r      <= acc_nxt;
    w_r        <= w_nxt;
    prod_r     <= prod_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[scan_r[AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_strobe  = out_vld_r;
  assign out_payload = out_r;

endmodule

`default_nettype wire

### rtl/core/ttht_checker.sv
`default_nettype none

`include "traversal_time_history_table_macros.svh"

module ttht_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input ttht_pkg::out_item_t out_payload
);

  import ttht_pkg::*;

  // an accepted item always occupies the block
  `TTHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // the result appears when the block frees up
  `TTHT_ASSERT_SAME(a_result_idle, out_strobe, !busy)
  // one result per item, never two in a row
  `TTHT_ASSERT_NEXT(a_single_result, out_strobe, !out_strobe)
  // only a query carries a travel time
  `TTHT_ASSERT_SAME(a_time_query, out_strobe && out_payload.status != ST_QUERY,
                    out_payload.travel_time == '0)

endmodule

bind traversal_time_history_table ttht_checker u_ttht_checker (.*);

`default_nettype wire

### sim/testbench.sv
`default_nettype none

module testbench;
  import ttht_pkg::*;

  localparam int          ENTRIES     = 256;
  localparam int          STALL_LIMIT = 20000;
  localparam int          HOT_KEYS    = 16;
  localparam logic [63:0] MAX_DUR     = 64'h7FFF_FFFF << 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_payload = '0;
  logic        out_strobe;
  out_item_t   out_payload;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_RETENTION;
  logic [15:0] cfg_data = '0;

  traversal_time_history_table u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_payload (in_payload),
    .out_strobe (out_strobe),
    .out_payload(out_payload),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table mirror
  key_t        tbl_key [ENTRIES];
  bit          tbl_valid [ENTRIES];
  logic [63:0] tbl_mean [ENTRIES];
  int unsigned tbl_conf [ENTRIES];
  logic [31:0] tbl_day [ENTRIES];
  logic [31:0] revision_count = '0;
  int unsigned used_count = 0;
  logic [15:0] retention = RetentionReset;
  logic [3:0]  prior = PriorReset;

  out_item_t   expected_results[$];
  int          errors = 0;
  int          sender_idle_pct = 0;
  int          stall_cycles = 0;
  logic [31:0] cur_day = 32'd100;
  key_t        hot_keys [HOT_KEYS];

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] sat_prod(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic int lookup_edge(input key_t k);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic bit edge_in_map(input key_t k);
    int x, y, z;
    x = k.x;
    y = k.y;
    z = k.z;
    return x >= 0 && x < MapWidthDef && y >= 0 && y < MapHeightDef && z >= 0
      && z <= ZLimit && k.tt < TrackTypesDef && k.tad < TadLimit;
  endfunction

  function automatic status_t record_time(input key_t k, input logic [63:0] dur,
                                          input logic [31:0] today);
    int idx;
    logic [63:0] total;
    if (!edge_in_map(k) || dur == 0 || dur > MAX_DUR) return ST_INVALID;
    idx = lookup_edge(k);
    if (idx < 0) begin
      if (used_count >= ENTRIES) return ST_FULL;
      for (idx = 0; idx < ENTRIES; idx++)
        if (!tbl_valid[idx]) break;
      tbl_valid[idx] = 1'b1;
      tbl_key[idx] = k;
      tbl_mean[idx] = dur;
      tbl_conf[idx] = 1;
      tbl_day[idx] = today;
      used_count++;
      revision_count++;
      return ST_INSERTED;
    end
    if (tbl_conf[idx] < MaxConf) begin
      total = sat_sum(sat_prod(tbl_mean[idx], 64'(tbl_conf[idx])), dur);
      tbl_conf[idx]++;
      tbl_mean[idx] = total / tbl_conf[idx];
    end else if (dur >= tbl_mean[idx]) begin
      tbl_mean[idx] += (dur - tbl_mean[idx]) / MaxConf;
    end else begin
      tbl_mean[idx] -= (tbl_mean[idx] - dur) / MaxConf;
    end
    tbl_day[idx] = today;
    revision_count++;
    return ST_UPDATED;
  endfunction

  function automatic void age_table(input logic [31:0] today);
    bit evicted;
    logic [31:0] age;
    evicted = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!tbl_valid[i]) continue;
      if (tbl_day[i] != today && tbl_conf[i] != 0) tbl_conf[i]--;
      age = today - tbl_day[i];
      if (tbl_day[i] > today || age > retention) begin
        tbl_valid[i] = 1'b0;
        used_count--;
        evicted = 1'b1;
      end
    end
    if (evicted) revision_count++;
  endfunction

  function automatic logic [63:0] blend_time(input key_t k, input logic [63:0] ff,
                                             input logic [63:0] act_el,
                                             input logic [9:0] act_n);
    int idx;
    logic [63:0] wt, w, m, r;
    idx = lookup_edge(k);
    if (idx < 0 && act_n == 0) return ff;
    wt = '0;
    w = '0;
    if (idx >= 0) begin
      wt = sat_prod(tbl_mean[idx], 64'(tbl_conf[idx]));
      w = 64'(tbl_conf[idx]);
    end
    if (act_n != 0) begin
      m = sat_prod(ff, 64'(act_n));
      wt = sat_sum(wt, act_el > m ? act_el : m);
      w += act_n;
    end
    wt = sat_sum(wt, sat_prod(ff, 64'(prior)));
    w += prior;
    if (w == 0) return ff;
    r = wt / w;
    return r > ff ? r : ff;
  endfunction

  function automatic out_item_t apply_item(input in_item_t it);
    out_item_t res;
    key_t k;
    k = {it.edge_x, it.edge_y, it.edge_z, it.edge_tad, it.track_type};
    res = '0;
    case (it.op)
      OP_RECORD: res.status = record_time(k, {16'd0, it.duration}, it.today);
      OP_AGING: begin
        age_table(it.today);
        res.status = ST_DONE;
      end
      OP_QUERY: begin
        res.travel_time = blend_time(k, it.free_flow_time, it.active_elapsed,
                                     it.active_count);
        res.status = ST_QUERY;
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
        used_count = 0;
        revision_count++;
        res.status = ST_DONE;
      end
    endcase
    res.revision = revision_count;
    res.entries_used = used_count[8:0];
    return res;
  endfunction

  // start is left high after an item is taken; only an idle gap in the next send or wait_idle lowers it
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_payload <= it;
    do @(posedge clk); while (busy);
    expected_results = {expected_results, apply_item(it)};
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_RETENTION) retention = value;
    else prior = value[3:0];
    @(posedge clk);
  endtask

  function automatic in_item_t make_item(input op_t op, input key_t k);
    in_item_t it;
    it = '0;
    it.op = op;
    {it.edge_x, it.edge_y, it.edge_z, it.edge_tad, it.track_type} = k;
    it.today = cur_day;
    return it;
  endfunction

  function automatic key_t valid_key();
    key_t k;
    k.x = 16'($urandom_range(MapWidthDef - 1));
    k.y = 16'($urandom_range(MapHeightDef - 1));
    k.z = 16'($urandom_range(ZLimit));
    k.tad = 9'($urandom_range(TadLimit - 1));
    k.tt = 8'($urandom_range(TrackTypesDef - 1));
    return k;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    key_t k;
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) k = hot_keys[$urandom_range(HOT_KEYS - 1)];
    else if (pick < 90) k = valid_key();
    else k = key_t'({$urandom, $urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 55) it = make_item(OP_RECORD, k);
    else if (pick < 88) it = make_item(OP_QUERY, k);
    else if (pick < 98) it = make_item(OP_AGING, k);
    else it = make_item(OP_CLEAR, k);
    pick = $urandom_range(99);
    if (pick < 70) it.duration = 48'($urandom_range(1, 32'h0010_0000));
    else if (pick < 80) it.duration = 48'({$urandom, $urandom});
    else if (pick < 88) it.duration = MAX_DUR[47:0] - 48'($urandom_range(1));
    else if (pick < 93) it.duration = MAX_DUR[47:0] + 48'($urandom_range(1, 3));
    else if (pick < 97) it.duration = '0;
    else it.duration = {16'd0, $urandom};
    if (it.op == OP_AGING && $urandom_range(1)) cur_day += $urandom_range(1, 3);
    it.today = cur_day - (($urandom_range(9) == 0) ? $urandom_range(3) : 0);
    if ($urandom_range(49) == 0) it.today = $urandom;
    it.free_flow_time = $urandom_range(1) ? rand64() : 64'($urandom_range(1, 1 << 24));
    it.active_elapsed = $urandom_range(1) ? rand64() : 64'($urandom);
    it.active_count = ($urandom_range(9) < 4) ? 10'd0 : 10'($urandom);
    return it;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_payload);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_payload.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_payload.status);
          errors++;
        end
        if (out_payload.travel_time !== want.travel_time) begin
          $display("%0t: travel_time expected %0h actual %0h", $time, want.travel_time,
                   out_payload.travel_time);
          errors++;
        end
        if (out_payload.revision !== want.revision) begin
          $display("%0t: revision expected %0d actual %0d", $time, want.revision,
                   out_payload.revision);
          errors++;
        end
        if (out_payload.entries_used !== want.entries_used) begin
          $display("%0t: entries_used expected %0d actual %0d", $time,
                   want.entries_used, out_payload.entries_used);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL traversal_time_history_table");
      $finish;
    end
  end

  task automatic test_record_and_query();
    key_t lo, hi, k;
    in_item_t it;
    lo = '0;
    hi = {16'sd12287, 16'sd12287, 16'sd1020, 9'd351, 8'd7};
    it = make_item(OP_RECORD, lo);
    it.duration = 48'd1;
    send_item(it);
    it = make_item(OP_RECORD, hi);
    it.duration = MAX_DUR[47:0];
    send_item(it);
    it.duration = 48'd5;
    send_item(it);
    // invalid edges and durations
    for (int i = 0; i < 9; i++) begin
      k = lo;
      case (i)
        0: k.x = -16'sd1;
        1: k.x = 16'sd12288;
        2: k.y = -16'sd32768;
        3: k.y = 16'sd32767;
        4: k.z = 16'sd1021;
        5: k.z = -16'sd1;
        6: k.tad = 9'd352;
        7: k.tad = 9'd511;
        default: k.tt = 8'd255;
      endcase
      it = make_item(OP_RECORD, k);
      it.duration = 48'd100;
      send_item(it);
    end
    it = make_item(OP_RECORD, lo);
    it.duration = '0;
    send_item(it);
    it.duration = MAX_DUR[47:0] + 48'd1;
    send_item(it);
    it.duration = '1;
    send_item(it);
    // known edge, unknown edge, saturating operands
    it = make_item(OP_QUERY, hi);
    it.free_flow_time = 64'd1000;
    send_item(it);
    it = make_item(OP_QUERY, {16'sd5, 16'sd5, 16'sd5, 9'd5, 8'd5});
    it.free_flow_time = 64'd777;
    send_item(it);
    it = make_item(OP_QUERY, hi);
    it.free_flow_time = '1;
    it.active_elapsed = '1;
    it.active_count = '1;
    send_item(it);
    it = make_item(OP_QUERY, lo);
    it.free_flow_time = 64'd3;
    it.active_elapsed = '1;
    it.active_count = 10'd1;
    send_item(it);
    it = make_item(OP_AGING, lo);
    it.today = cur_day + 1;
    send_item(it);
    send_item(make_item(OP_CLEAR, lo));
    wait_idle();
  endtask

  task automatic test_zero_weight();
    key_t k;
    in_item_t it;
    write_reg(CFG_PRIOR, 16'd0);
    k = valid_key();
    it = make_item(OP_RECORD, k);
    it.duration = 48'd4242;
    send_item(it);
    // one day later the single sample has no confidence left
    it = make_item(OP_AGING, k);
    it.today = cur_day + 1;
    send_item(it);
    it = make_item(OP_QUERY, k);
    it.free_flow_time = 64'd99;
    send_item(it);
    it.active_count = 10'd2;
    it.active_elapsed = 64'd1000;
    send_item(it);
    wait_idle();
    write_reg(CFG_PRIOR, 16'd15);
    write_reg(CFG_RETENTION, 16'd0);
  endtask

  task automatic test_full_table();
    in_item_t it;
    send_item(make_item(OP_CLEAR, '0));
    for (int i = 0; i < ENTRIES + 3; i++) begin
      it = make_item(OP_RECORD, {16'(i), 16'(i * 7), 16'd0, 9'd0, 8'd1});
      it.duration = 48'($urandom_range(1, 1 << 20));
      it.today = cur_day - ((i < 128) ? 1 : 0);
      send_item(it);
    end
    it = make_item(OP_RECORD, {16'd3, 16'd21, 16'd0, 9'd0, 8'd1});
    it.duration = 48'd50;
    send_item(it);
    // retention zero drops the entries last recorded a day earlier
    send_item(make_item(OP_AGING, '0));
    it.today = cur_day + 32'hFFFF_0000;
    it.op = OP_AGING;
    send_item(it);
    wait_idle();
  endtask

  task automatic test_random(input int idle_pct, input int count);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(199) == 0) hot_keys[$urandom_range(HOT_KEYS - 1)] = valid_key();
      send_item(random_item());
    end
    wait_idle();
    sender_idle_pct = 0;
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < HOT_KEYS; i++) hot_keys[i] = valid_key();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_record_and_query();
    test_zero_weight();
    test_full_table();
    write_reg(CFG_RETENTION, 16'd30);
    write_reg(CFG_PRIOR, 16'd4);
    test_random(0, 280);
    write_reg(CFG_RETENTION, 16'd2);
    write_reg(CFG_PRIOR, 16'd15);
    test_random(68, 280);
    write_reg(CFG_RETENTION, 16'd65535);
    write_reg(CFG_PRIOR, 16'd0);
    test_random(32, 280);
    write_reg(CFG_RETENTION, 16'($urandom_range(1, 20)));
    write_reg(CFG_PRIOR, 16'($urandom_range(15)));
    test_random(0, 280);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS traversal_time_history_table");
    else $display("FAIL traversal_time_history_table");
    $finish;
  end

endmodule

`default_nettype wire
